/* hw/rtl/jsv_pkg.sv */
// ----------------------------------------------------------------------------
// jsv_pkg
// Types, grammar modes and character helpers of the JSON syntax validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

	typedef enum logic [4:0] {
		M_VALUE     = 5'd0,
		M_ARR_FIRST = 5'd1,
		M_OBJ_FIRST = 5'd2,
		M_OBJ_KEY   = 5'd3,
		M_KEY       = 5'd4,
		M_KEY_ESC   = 5'd5,
		M_KEY_HEX   = 5'd6,
		M_COLON     = 5'd7,
		M_STR       = 5'd8,
		M_STR_ESC   = 5'd9,
		M_STR_HEX   = 5'd10,
		M_LIT       = 5'd11,
		M_N_MINUS   = 5'd12,
		M_N_ZERO    = 5'd13,
		M_N_INT     = 5'd14,
		M_N_DOT     = 5'd15,
		M_N_FRAC    = 5'd16,
		M_N_EXP     = 5'd17,
		M_N_ESIGN   = 5'd18,
		M_N_EDIG    = 5'd19,
		M_AFTER     = 5'd20,
		M_DONE      = 5'd21
	} mode_t;

	localparam logic [1:0] VERDICT_PENDING = 2'd0;
	localparam logic [1:0] VERDICT_VALID   = 2'd1;
	localparam logic [1:0] VERDICT_INVALID = 2'd2;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam logic [6:0] LIMIT_RESET = 7'd64;

	typedef struct packed {
		logic push;
		logic pop;
		logic is_obj;
	} stack_op_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h0a) || (b == 8'h0d) || (b == 8'h09);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
			((b >= 8'h41) && (b <= 8'h46));
	endfunction

	function automatic logic is_num_term(input mode_t m);
		return (m == M_N_ZERO) || (m == M_N_INT) || (m == M_N_FRAC) || (m == M_N_EDIG);
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] w);
		return (w == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		case (w)
			LIT_TRUE: begin
				case (i)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (i)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (i)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/jsv_in_if.sv */
// ----------------------------------------------------------------------------
// jsv_in_if
// Byte channel into the validator.
// ----------------------------------------------------------------------------
interface jsv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

/* hw/rtl/jsv_out_if.sv */
// ----------------------------------------------------------------------------
// jsv_out_if
// Result channel out of the validator.
// ----------------------------------------------------------------------------
interface jsv_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [6:0] open_depth;
	logic       document_done;

	modport source (output valid, output verdict, output open_depth,
		output document_done, input ready);
	modport sink (input valid, input verdict, input open_depth,
		input document_done, output ready);
endinterface

/* hw/rtl/jsv_stack.sv */
// ----------------------------------------------------------------------------
// jsv_stack
// Container stack memory with a registered top entry. On every transfer the read
// port prefetches the entry below the top so that a pop has the new top one
// transfer later.
// ----------------------------------------------------------------------------
module jsv_stack
	import jsv_pkg::*;
#(
	parameter int MAX_DEPTH = 64,
	parameter int DW        = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          clr,
	input  logic [DW-1:0] depth,
	input  stack_op_t     op,
	output logic          top
);

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic          mem [MAX_DEPTH];
	logic          rd_q;
	logic          top_q;
	logic          pop_s1;
	logic [DW-1:0] rd_depth;

	assign top      = pop_s1 ? rd_q : top_q;
	assign rd_depth = depth - DW'(2);

	always_ff @(posedge clk) begin
		if (en && op.push) begin
			mem[depth[AW-1:0]] <= op.is_obj;
		end
		if (en) begin
			rd_q <= mem[rd_depth[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_s1 <= 1'b0;
			top_q  <= 1'b0;
		end else if (en) begin
			pop_s1 <= op.pop && !clr;
			if (op.push) begin
				top_q <= op.is_obj;
			end else begin
				top_q <= top;
			end
		end
	end

endmodule

/* hw/rtl/jsv_parse.sv */
// ----------------------------------------------------------------------------
// jsv_parse
// Grammar step: next document state and stack operation for one byte.
// ----------------------------------------------------------------------------
module jsv_parse
	import jsv_pkg::*;
#(
	parameter int MAX_DEPTH = 64,
	parameter int DW        = 7
) (
	input  logic [7:0]    b,
	input  logic [6:0]    limit,
	input  logic          top,
	input  mode_t         mode,
	input  logic [DW-1:0] depth,
	input  logic [2:0]    hex_left,
	input  logic [1:0]    lit_w,
	input  logic [2:0]    lit_i,
	input  logic          err,
	output mode_t         n_mode,
	output logic [DW-1:0] n_depth,
	output logic [2:0]    n_hex,
	output logic [1:0]    n_lit_w,
	output logic [2:0]    n_lit_i,
	output logic          n_err,
	output stack_op_t     op
);

	localparam int LW = (DW > 7) ? DW : 7;
	localparam logic [LW-1:0] MAXD = LW'(MAX_DEPTH);

	logic [LW-1:0] lim;
	logic [LW-1:0] depth_x;

	assign depth_x = LW'(depth);
	assign lim     = (LW'(limit) > MAXD) ? MAXD : LW'(limit);

	always_comb begin
		mode_t      m;
		logic       go;
		logic       start;
		logic       cont;
		logic [1:0] w;
		logic [2:0] i;
		logic       close;
		logic       close_obj;

		n_mode    = mode;
		n_depth   = depth;
		n_hex     = hex_left;
		n_lit_w   = lit_w;
		n_lit_i   = lit_i;
		n_err     = err;
		op        = '0;
		m         = mode;
		go        = !err;
		start     = 1'b0;
		cont      = 1'b0;
		close     = 1'b0;
		close_obj = 1'b0;
		w         = (lit_w > LIT_NULL) ? LIT_NULL : lit_w;
		i         = (lit_i < lit_len(w)) ? lit_i : 3'd0;

		if (go && (mode inside {[M_N_MINUS:M_N_EDIG]})) begin
			case (mode)
				M_N_MINUS: begin
					if (b == "0") begin
						n_mode = M_N_ZERO; cont = 1'b1;
					end else if (is_digit(b)) begin
						n_mode = M_N_INT; cont = 1'b1;
					end
				end
				M_N_ZERO, M_N_INT: begin
					if (is_digit(b) && mode == M_N_INT) begin
						cont = 1'b1;
					end else if (b == ".") begin
						n_mode = M_N_DOT; cont = 1'b1;
					end else if (b == "e" || b == "E") begin
						n_mode = M_N_EXP; cont = 1'b1;
					end
				end
				M_N_DOT: begin
					if (is_digit(b)) begin
						n_mode = M_N_FRAC; cont = 1'b1;
					end
				end
				M_N_FRAC: begin
					if (is_digit(b)) begin
						cont = 1'b1;
					end else if (b == "e" || b == "E") begin
						n_mode = M_N_EXP; cont = 1'b1;
					end
				end
				M_N_EXP: begin
					if (b == "+" || b == "-") begin
						n_mode = M_N_ESIGN; cont = 1'b1;
					end else if (is_digit(b)) begin
						n_mode = M_N_EDIG; cont = 1'b1;
					end
				end
				M_N_ESIGN: begin
					if (is_digit(b)) begin
						n_mode = M_N_EDIG; cont = 1'b1;
					end
				end
				default: begin
					cont = is_digit(b);
				end
			endcase
			if (cont) begin
				go = 1'b0;
			end else if (!is_num_term(mode)) begin
				n_err = 1'b1;
				go    = 1'b0;
			end else begin
				m      = (depth != '0) ? M_AFTER : M_DONE;
				n_mode = m;
			end
		end

		if (go) begin
			case (m)
				M_VALUE: start = 1'b1;
				M_ARR_FIRST: begin
					if (b == "]") close = 1'b1;
					else start = 1'b1;
				end
				M_OBJ_FIRST, M_OBJ_KEY: begin
					if (!is_ws(b)) begin
						if (b == "\"") n_mode = M_KEY;
						else if (b == "}" && m == M_OBJ_FIRST) begin
							close = 1'b1; close_obj = 1'b1;
						end else n_err = 1'b1;
					end
				end
				M_KEY, M_STR: begin
					if (b == 8'h00) n_err = 1'b1;
					else if (b == "\\") n_mode = mode_t'(m + 5'd1);
					else if (b == "\"") begin
						if (m == M_KEY) n_mode = M_COLON;
						else n_mode = (depth != '0) ? M_AFTER : M_DONE;
					end
				end
				M_KEY_ESC, M_STR_ESC: begin
					case (b)
						"\"", "\\", "/", "b", "f", "n", "r", "t":
							n_mode = mode_t'(m - 5'd1);
						"u": begin
							n_hex  = 3'd4;
							n_mode = mode_t'(m + 5'd1);
						end
						default: n_err = 1'b1;
					endcase
				end
				M_KEY_HEX, M_STR_HEX: begin
					if (!is_hex(b)) n_err = 1'b1;
					else begin
						n_hex = hex_left - 3'd1;
						if (n_hex == 3'd0) n_mode = mode_t'(m - 5'd2);
					end
				end
				M_COLON: begin
					if (!is_ws(b)) begin
						if (b == ":") n_mode = M_VALUE;
						else n_err = 1'b1;
					end
				end
				M_LIT: begin
					if (b != lit_char(w, i)) n_err = 1'b1;
					else begin
						n_lit_i = i + 3'd1;
						if (n_lit_i >= lit_len(w))
							n_mode = (depth != '0) ? M_AFTER : M_DONE;
					end
				end
				M_AFTER: begin
					if (!is_ws(b)) begin
						if (b == ",") n_mode = top ? M_OBJ_KEY : M_VALUE;
						else if (b == "]") close = 1'b1;
						else if (b == "}") begin
							close = 1'b1; close_obj = 1'b1;
						end else n_err = 1'b1;
					end
				end
				M_DONE: begin
					if (!is_ws(b)) n_err = 1'b1;
				end
				default: n_err = 1'b1;
			endcase
		end

		if (start && !is_ws(b)) begin
			case (b)
				"\"": n_mode = M_STR;
				"[", "{": begin
					if (depth_x >= lim) n_err = 1'b1;
					else begin
						op.push   = 1'b1;
						op.is_obj = (b == "{");
						n_depth   = depth + DW'(1);
						n_mode    = (b == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
					end
				end
				"t", "f", "n": begin
					n_lit_w = (b == "t") ? LIT_TRUE : (b == "f") ? LIT_FALSE : LIT_NULL;
					n_lit_i = 3'd1;
					n_mode  = M_LIT;
				end
				"-": n_mode = M_N_MINUS;
				"0": n_mode = M_N_ZERO;
				default: begin
					if (is_digit(b)) n_mode = M_N_INT;
					else n_err = 1'b1;
				end
			endcase
		end

		if (close) begin
			if (depth == '0 || top != close_obj) n_err = 1'b1;
			else begin
				op.pop  = 1'b1;
				n_depth = depth - DW'(1);
				n_mode  = (n_depth != '0) ? M_AFTER : M_DONE;
			end
		end
	end

endmodule

/* hw/rtl/json_syntax_validator.sv */
// ----------------------------------------------------------------------------
// json_syntax_validator
// Streaming JSON syntax check, one byte per transfer.
// Each byte's result is registered in the output register at its input transfer.
// Throughput: one byte per cycle while the output channel does not stall.
// Reset: asynchronous; document state cleared and nesting limit set to 64.
// The document state also returns to reset after each final byte.
// ----------------------------------------------------------------------------
module json_syntax_validator
	import jsv_pkg::*;
#(
	parameter int MAX_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	jsv_in_if.sink     in_ch,
	jsv_out_if.source  out_ch
);

	localparam int DW = $clog2(MAX_DEPTH + 1);

	logic [6:0]    limit_q;
	mode_t         mode_q;
	logic [DW-1:0] depth_q;
	logic [2:0]    hex_q;
	logic [1:0]    lit_w_q;
	logic [2:0]    lit_i_q;
	logic          err_q;

	mode_t         n_mode;
	logic [DW-1:0] n_depth;
	logic [2:0]    n_hex;
	logic [1:0]    n_lit_w;
	logic [2:0]    n_lit_i;
	logic          n_err;
	stack_op_t     op;
	logic          top;
	logic          xfer;
	logic          last;

	logic          out_valid_q;
	logic [1:0]    verdict_q;
	logic [6:0]    depth_out_q;
	logic          done_q;
	logic [1:0]    verdict;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign xfer        = in_ch.valid && in_ch.ready;
	assign last        = in_ch.last_byte;

	jsv_stack #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (xfer),
		.clr   (last),
		.depth (depth_q),
		.op    (op),
		.top   (top)
	);

	jsv_parse #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_parse (
		.b       (in_ch.byte_value),
		.limit   (limit_q),
		.top     (top),
		.mode    (mode_q),
		.depth   (depth_q),
		.hex_left(hex_q),
		.lit_w   (lit_w_q),
		.lit_i   (lit_i_q),
		.err     (err_q),
		.n_mode  (n_mode),
		.n_depth (n_depth),
		.n_hex   (n_hex),
		.n_lit_w (n_lit_w),
		.n_lit_i (n_lit_i),
		.n_err   (n_err),
		.op      (op)
	);

	always_comb begin
		if (n_err) verdict = VERDICT_INVALID;
		else if (!last) verdict = VERDICT_PENDING;
		else if (n_mode == M_DONE || (n_depth == '0 && is_num_term(n_mode)))
			verdict = VERDICT_VALID;
		else verdict = VERDICT_INVALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			mode_q      <= M_VALUE;
			depth_q     <= '0;
			hex_q       <= '0;
			lit_w_q     <= '0;
			lit_i_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (xfer) begin
				if (last) begin
					mode_q  <= M_VALUE;
					depth_q <= '0;
					hex_q   <= '0;
					lit_w_q <= '0;
					lit_i_q <= '0;
					err_q   <= 1'b0;
				end else begin
					mode_q  <= n_mode;
					depth_q <= n_depth;
					hex_q   <= n_hex;
					lit_w_q <= n_lit_w;
					lit_i_q <= n_lit_i;
					err_q   <= n_err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			verdict_q   <= verdict;
			depth_out_q <= 7'(n_depth);
			done_q      <= last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.verdict       = verdict_q;
	assign out_ch.open_depth    = depth_out_q;
	assign out_ch.document_done = done_q;

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.push && op.pop))
		else $error("push and pop in the same transfer");

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth above maximum");

	a_err_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && err_q && !last |=> err_q)
		else $error("error cleared before final byte");

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last |=> depth_q == '0 && !err_q && mode_q == M_VALUE)
		else $error("document state not cleared after final byte");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the streaming JSON syntax validator. A short directed table of
// bytes comes first: some rows carry their expected result, the rest use the
// byte-level grammar predictor. Random documents follow. Most are well formed
// with random content, some are damaged, and some are deep nests that test the
// nesting limit. They run under several nesting limits. Both channels idle at
// random, and every result is compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb_top;
	import jsv_pkg::*;

	typedef struct {
		logic [1:0] verdict;
		logic [6:0] depth;
		logic       done;
	} verdict_t;

	typedef struct {
		byte unsigned b;
		bit           last;
		bit           typed;
		logic [1:0]   verdict;
		logic [6:0]   depth;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = 7'd0;

	jsv_in_if  in_ch ();
	jsv_out_if out_ch ();

	json_syntax_validator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #2 clk = ~clk;

	// grammar predictor state
	mode_t      gmode;
	bit         kind_stack [64];
	int         depth_cnt;
	int         hex_cnt;
	int         lit_sel;
	int         lit_pos;
	bit         err_seen;
	int         limit_reg = 64;

	verdict_t   verdict_q [$];
	int         errors = 0;
	bit         src_calm = 1'b0;
	bit         sink_calm = 1'b0;
	int         idle_cycles = 0;

	function automatic bit ws_char(byte unsigned b);
		return b == 8'h20 || b == 8'h0a || b == 8'h0d || b == 8'h09;
	endfunction

	function automatic bit dig_char(byte unsigned b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit hex_char(byte unsigned b);
		return dig_char(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic bit num_mode(mode_t m);
		return m >= M_N_MINUS && m <= M_N_EDIG;
	endfunction

	function automatic bit num_final(mode_t m);
		return m == M_N_ZERO || m == M_N_INT || m == M_N_FRAC || m == M_N_EDIG;
	endfunction

	function automatic byte unsigned lit_byte(int w, int i);
		string s;
		s = (w == LIT_TRUE) ? "true" : (w == LIT_FALSE) ? "false" : "null";
		return (i < s.len()) ? s[i] : 8'h00;
	endfunction

	function automatic void doc_clear();
		gmode = M_VALUE;
		depth_cnt = 0;
		hex_cnt = 0;
		lit_sel = 0;
		lit_pos = 0;
		err_seen = 1'b0;
	endfunction

	function automatic void value_closed();
		gmode = (depth_cnt > 0) ? M_AFTER : M_DONE;
	endfunction

	function automatic void open_level(bit is_obj);
		int lim;
		lim = (limit_reg > 64) ? 64 : limit_reg;
		if (depth_cnt >= lim) begin
			err_seen = 1'b1;
			return;
		end
		kind_stack[depth_cnt] = is_obj;
		depth_cnt++;
		gmode = is_obj ? M_OBJ_FIRST : M_ARR_FIRST;
	endfunction

	function automatic bit top_is_obj();
		return (depth_cnt > 0) ? kind_stack[depth_cnt - 1] : 1'b0;
	endfunction

	function automatic void close_level(bit is_obj);
		if (depth_cnt == 0 || top_is_obj() != is_obj) begin
			err_seen = 1'b1;
			return;
		end
		depth_cnt--;
		value_closed();
	endfunction

	function automatic bit number_next(byte unsigned b);
		bit d, e;
		d = dig_char(b);
		e = (b == "e" || b == "E");
		case (gmode)
			M_N_MINUS: begin
				if (b == "0") begin gmode = M_N_ZERO; return 1; end
				if (d) begin gmode = M_N_INT; return 1; end
				return 0;
			end
			M_N_ZERO, M_N_INT: begin
				if (d && gmode == M_N_INT) return 1;
				if (b == ".") begin gmode = M_N_DOT; return 1; end
				if (e) begin gmode = M_N_EXP; return 1; end
				return 0;
			end
			M_N_DOT: begin
				if (d) begin gmode = M_N_FRAC; return 1; end
				return 0;
			end
			M_N_FRAC: begin
				if (d) return 1;
				if (e) begin gmode = M_N_EXP; return 1; end
				return 0;
			end
			M_N_EXP: begin
				if (b == "+" || b == "-") begin gmode = M_N_ESIGN; return 1; end
				if (d) begin gmode = M_N_EDIG; return 1; end
				return 0;
			end
			M_N_ESIGN: begin
				if (d) begin gmode = M_N_EDIG; return 1; end
				return 0;
			end
			default: return d;
		endcase
	endfunction

	function automatic void value_start(byte unsigned b);
		if (ws_char(b)) return;
		case (b)
			"\"": gmode = M_STR;
			"[": open_level(1'b0);
			"{": open_level(1'b1);
			"t", "f", "n": begin
				lit_sel = int'((b == "t") ? LIT_TRUE : (b == "f") ? LIT_FALSE : LIT_NULL);
				lit_pos = 1;
				gmode = M_LIT;
			end
			"-": gmode = M_N_MINUS;
			"0": gmode = M_N_ZERO;
			default: begin
				if (dig_char(b)) gmode = M_N_INT;
				else err_seen = 1'b1;
			end
		endcase
	endfunction

	function automatic void string_next(byte unsigned b, mode_t base);
		int off;
		off = int'(gmode) - int'(base);
		if (off == 0) begin
			if (b == 8'h00) err_seen = 1'b1;
			else if (b == "\\") gmode = mode_t'(int'(base) + 1);
			else if (b == "\"") begin
				if (base == M_KEY) gmode = M_COLON;
				else value_closed();
			end
		end else if (off == 1) begin
			case (b)
				"\"", "\\", "/", "b", "f", "n", "r", "t": gmode = base;
				"u": begin hex_cnt = 4; gmode = mode_t'(int'(base) + 2); end
				default: err_seen = 1'b1;
			endcase
		end else begin
			if (!hex_char(b)) begin
				err_seen = 1'b1;
				return;
			end
			hex_cnt = (hex_cnt - 1) & 7;
			if (hex_cnt == 0) gmode = base;
		end
	endfunction

	function automatic void grammar_byte(byte unsigned b);
		if (num_mode(gmode)) begin
			if (number_next(b)) return;
			if (!num_final(gmode)) begin
				err_seen = 1'b1;
				return;
			end
			value_closed();
		end
		case (gmode)
			M_VALUE: value_start(b);
			M_ARR_FIRST: begin
				if (b == "]") close_level(1'b0);
				else value_start(b);
			end
			M_OBJ_FIRST, M_OBJ_KEY: begin
				if (!ws_char(b)) begin
					if (b == "\"") gmode = M_KEY;
					else if (b == "}" && gmode == M_OBJ_FIRST) close_level(1'b1);
					else err_seen = 1'b1;
				end
			end
			M_KEY, M_KEY_ESC, M_KEY_HEX: string_next(b, M_KEY);
			M_STR, M_STR_ESC, M_STR_HEX: string_next(b, M_STR);
			M_COLON: begin
				if (!ws_char(b)) begin
					if (b == ":") gmode = M_VALUE;
					else err_seen = 1'b1;
				end
			end
			M_LIT: begin
				if (b != lit_byte(lit_sel, lit_pos)) err_seen = 1'b1;
				else begin
					lit_pos++;
					if (lit_pos >= ((lit_sel == LIT_FALSE) ? 5 : 4)) value_closed();
				end
			end
			M_AFTER: begin
				if (!ws_char(b)) begin
					if (b == ",") gmode = top_is_obj() ? M_OBJ_KEY : M_VALUE;
					else if (b == "]") close_level(1'b0);
					else if (b == "}") close_level(1'b1);
					else err_seen = 1'b1;
				end
			end
			M_DONE: if (!ws_char(b)) err_seen = 1'b1;
			default: err_seen = 1'b1;
		endcase
	endfunction

	function automatic verdict_t predict_verdict(byte unsigned b, bit last);
		verdict_t r;
		if (!err_seen) grammar_byte(b);
		if (err_seen) r.verdict = VERDICT_INVALID;
		else if (!last) r.verdict = VERDICT_PENDING;
		else if (gmode == M_DONE || (depth_cnt == 0 && num_final(gmode)))
			r.verdict = VERDICT_VALID;
		else r.verdict = VERDICT_INVALID;
		r.depth = depth_cnt[6:0];
		r.done = last;
		if (last) doc_clear();
		return r;
	endfunction

	task automatic report(string what, logic [9:0] got, logic [9:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// one byte per call; valid stays high between back-to-back transfers
	task automatic send_byte(byte unsigned b, bit last, bit typed,
			logic [1:0] v, logic [6:0] d);
		int gap;
		verdict_t r;
		gap = src_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_value <= b;
		in_ch.last_byte <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		r = predict_verdict(b, last);
		if (typed) begin
			r.verdict = v;
			r.depth = d;
		end
		verdict_q.push_back(r);
	endtask

	// drop valid, hold until every result is back, then write the limit
	task automatic write_limit(logic [6:0] val);
		in_ch.valid <= 1'b0;
		while (verdict_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = int'(val);
	endtask

	function automatic void add_ws(ref byte unsigned q[$]);
		int n;
		byte unsigned ws [4] = '{8'h20, 8'h09, 8'h0a, 8'h0d};
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) q.push_back(ws[$urandom_range(0, 3)]);
	endfunction

	function automatic void add_string(ref byte unsigned q[$]);
		int n;
		byte unsigned esc [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
		string hx;
		hx = "0123456789abcdefABCDEF";
		q.push_back("\"");
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: begin q.push_back("\\"); q.push_back(esc[$urandom_range(0, 7)]); end
				1: begin
					q.push_back("\\");
					q.push_back("u");
					repeat (4) q.push_back(hx[$urandom_range(0, 21)]);
				end
				2: q.push_back(8'($urandom_range(128, 255)));
				default: begin
					byte unsigned c;
					c = 8'($urandom_range(1, 127));
					if (c == "\"" || c == "\\") c = "x";
					q.push_back(c);
				end
			endcase
		end
		q.push_back("\"");
	endfunction

	function automatic void add_value(ref byte unsigned q[$], input int lvl);
		int k, n;
		string s;
		k = $urandom_range(0, (lvl >= 3) ? 2 : 4);
		add_ws(q);
		case (k)
			0: begin
				if ($urandom_range(0, 1)) q.push_back("-");
				if ($urandom_range(0, 3) == 0) q.push_back("0");
				else begin
					q.push_back(8'($urandom_range("1", "9")));
					repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range("0", "9")));
				end
				if ($urandom_range(0, 2) == 0) begin
					q.push_back(".");
					repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range("0", "9")));
				end
				if ($urandom_range(0, 2) == 0) begin
					q.push_back($urandom_range(0, 1) ? "e" : "E");
					case ($urandom_range(0, 2))
						0: q.push_back("+");
						1: q.push_back("-");
						default: ;
					endcase
					repeat ($urandom_range(1, 2)) q.push_back(8'($urandom_range("0", "9")));
				end
			end
			1: add_string(q);
			2: begin
				case ($urandom_range(0, 2))
					0: s = "true";
					1: s = "false";
					default: s = "null";
				endcase
				foreach (s[i]) q.push_back(s[i]);
			end
			3: begin
				q.push_back("[");
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					if (i > 0) q.push_back(",");
					add_value(q, lvl + 1);
				end
				add_ws(q);
				q.push_back("]");
			end
			default: begin
				q.push_back("{");
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					if (i > 0) q.push_back(",");
					add_ws(q);
					add_string(q);
					add_ws(q);
					q.push_back(":");
					add_value(q, lvl + 1);
				end
				add_ws(q);
				q.push_back("}");
			end
		endcase
		add_ws(q);
	endfunction

	function automatic void add_nest(ref byte unsigned q[$]);
		int d;
		bit kinds [$];
		d = $urandom_range(1, 70);
		repeat (d) begin
			kinds.push_back(1'($urandom_range(0, 1)));
			if (kinds[$]) begin
				q.push_back("{");
				q.push_back("\"");
				q.push_back("k");
				q.push_back("\"");
				q.push_back(":");
			end else q.push_back("[");
		end
		q.push_back("7");
		while (kinds.size() > 0) q.push_back(kinds.pop_back() ? "}" : "]");
	endfunction

	task automatic run_docs(int n_bytes);
		int sent;
		byte unsigned doc [$];
		sent = 0;
		while (sent < n_bytes) begin
			doc.delete();
			src_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) add_nest(doc);
			else add_value(doc, 0);
			case ($urandom_range(0, 9))
				0: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
				1: while (doc.size() > 1 && $urandom_range(0, 3) != 0) void'(doc.pop_back());
				2: doc.push_back(8'($urandom_range(0, 255)));
				default: ;
			endcase
			foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1, 1'b0, 2'd0, 7'd0);
			sent += doc.size();
		end
	endtask

	// result side: random stalls, compare at each transfer
	initial begin
		verdict_t want;
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0) sink_calm = ~sink_calm;
			stall = sink_calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			if (verdict_q.size() == 0) report("unexpected result", 10'd0, 10'd0);
			else begin
				want = verdict_q.pop_front();
				if (out_ch.verdict !== want.verdict)
					report("verdict", out_ch.verdict, want.verdict);
				if (out_ch.open_depth !== want.depth)
					report("open_depth", out_ch.open_depth, want.depth);
				if (out_ch.document_done !== want.done)
					report("document_done", out_ch.document_done, want.done);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_rows [$];
		logic [6:0] limits [6] = '{7'd1, 7'd0, 7'd127, 7'd5, 7'd64, 7'd2};
		in_ch.valid = 1'b0;
		in_ch.byte_value = 8'h00;
		in_ch.last_byte = 1'b0;
		doc_clear();
		dir_rows = '{
			'{"{", 0, 1, VERDICT_PENDING, 7'd1},
			'{"}", 1, 1, VERDICT_VALID, 7'd0},
			'{"[", 0, 1, VERDICT_PENDING, 7'd1},
			'{"}", 1, 1, VERDICT_INVALID, 7'd1},
			'{8'h00, 1, 1, VERDICT_INVALID, 7'd0},
			'{"0", 1, 1, VERDICT_VALID, 7'd0},
			'{" ", 1, 1, VERDICT_INVALID, 7'd0},
			'{8'hff, 1, 1, VERDICT_INVALID, 7'd0},
			'{"t", 0, 0, 0, 0}, '{"r", 0, 0, 0, 0}, '{"u", 0, 0, 0, 0},
			'{"e", 0, 0, 0, 0}, '{8'h0a, 1, 0, 0, 0},
			'{"\"", 0, 0, 0, 0}, '{8'h80, 0, 0, 0, 0}, '{"\\", 0, 0, 0, 0},
			'{"u", 0, 0, 0, 0}, '{"A", 0, 0, 0, 0}, '{"f", 0, 0, 0, 0},
			'{"0", 0, 0, 0, 0}, '{"9", 0, 0, 0, 0}, '{"\"", 1, 0, 0, 0},
			'{"-", 0, 1, VERDICT_PENDING, 7'd0},
			'{"1", 0, 1, VERDICT_PENDING, 7'd0},
			'{"e", 1, 1, VERDICT_INVALID, 7'd0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].verdict, dir_rows[i].depth);
		run_docs(150);
		foreach (limits[i]) begin
			write_limit(limits[i]);
			run_docs(160);
		end
		in_ch.valid <= 1'b0;
		while (verdict_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
